### hw/rtl/full_linear_convolution_top_defines.svh
// assertion macros used by the checker file
`ifndef FULL_LINEAR_CONVOLUTION_TOP_DEFINES_SVH
`define FULL_LINEAR_CONVOLUTION_TOP_DEFINES_SVH

// antecedent in this cycle implies consequent in the next cycle
`define FLC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flc assertion failed");

// antecedent implies consequent in the same cycle
`define FLC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flc assertion failed");

`endif

### hw/rtl/flc_pkg.sv
package flc_pkg;

   localparam int MAX_TAPS  = 16;
   localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
   localparam int TAP_IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int SAMPLE_W  = 16;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int ACC_W     = 40;
   localparam int LEN_W     = 16;
   localparam int CNT_W     = LEN_W + 1;

   localparam logic OP_COEF   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load_coef;
      logic start_sample;
      logic shift_zero;
      logic mac_start;
      logic mac_run;
      logic emit;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mac_busy;
      logic suppress;
      logic flush_more;
      logic seq_last;
      logic out_free;
   } stat_type;

endpackage

### hw/rtl/flc_ctrl.sv
module flc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tuser,
   output flc_pkg::cmd_type cmd,
   input  flc_pkg::stat_type stat
);
   import flc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_MAC   = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_NEXT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_COEF) begin
                  cmd.load_coef = 1'b1;
               end else begin
                  cmd.start_sample = 1'b1;
                  state_in         = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            cmd.mac_start = 1'b1;
            state_in      = stat.suppress ? ST_NEXT : ST_MAC;
         end
         ST_MAC: begin
            cmd.mac_run = 1'b1;
            if (!stat.mac_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (stat.flush_more) begin
               cmd.shift_zero = 1'b1;
               state_in       = ST_CHECK;
            end else begin
               cmd.finish = stat.seq_last;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/flc_datapath.sv
module flc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [flc_pkg::SAMPLE_W-1:0] in_value,
   input  logic                                in_last,
   input  logic                                csr_valid,
   input  logic [flc_pkg::LEN_W-1:0]           csr_data,
   input  flc_pkg::cmd_type                    cmd,
   output flc_pkg::stat_type                   stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [flc_pkg::ACC_W-1:0]           rsp_tdata,
   output logic                                rsp_tlast
);
   import flc_pkg::*;

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   logic signed [SAMPLE_W-1:0] kern_ff [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] kern_in [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] hist_ff [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] hist_in [MAX_TAPS];

   logic [TAP_CNT_W-1:0] tap_cnt_ff, tap_cnt_in, coef_base;
   logic                 closed_ff, closed_in;
   logic [TAP_CNT_W-1:0] flush_ff, flush_in;
   logic                 last_ff, last_in;
   logic [TAP_CNT_W-1:0] mac_idx_ff, mac_idx_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                 prod_vld_ff, prod_vld_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [ACC_W:0]       acc_sum;
   logic [CNT_W-1:0]     emit_cnt_ff, emit_cnt_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 len_hit;
   logic                 mac_active;

   assign coef_base  = closed_ff ? '0 : tap_cnt_ff;
   assign mac_active = (mac_idx_ff < tap_cnt_ff);
   assign len_hit    = (len_ff != '0) && ({1'b0, len_ff} == emit_cnt_ff + CNT_W'(1));
   assign prod_in    = kern_ff[mac_idx_ff[TAP_IDX_W-1:0]] * hist_ff[mac_idx_ff[TAP_IDX_W-1:0]];
   assign acc_sum    = {acc_ff[ACC_W-1], acc_ff}
                     + {{(ACC_W+1-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      kern_in    = kern_ff;
      tap_cnt_in = tap_cnt_ff;
      closed_in  = closed_ff;
      if (cmd.load_coef) begin
         closed_in  = in_last;
         tap_cnt_in = coef_base;
         if (coef_base < TAP_CNT_W'(MAX_TAPS)) begin
            kern_in[coef_base[TAP_IDX_W-1:0]] = in_value;
            tap_cnt_in = coef_base + TAP_CNT_W'(1);
         end
      end
   end

   // history shift line, cleared at the end of a signal
   always_comb begin
      hist_in = hist_ff;
      if (cmd.start_sample || cmd.shift_zero) begin
         for (int i = 1; i < MAX_TAPS; i++) begin
            hist_in[i] = hist_ff[i-1];
         end
         hist_in[0] = cmd.start_sample ? in_value : '0;
      end
      if (cmd.finish) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            hist_in[i] = '0;
         end
      end
   end

   always_comb begin
      flush_in = flush_ff;
      last_in  = last_ff;
      if (cmd.start_sample) begin
         last_in  = in_last;
         flush_in = (in_last && tap_cnt_ff > TAP_CNT_W'(1)) ? tap_cnt_ff - TAP_CNT_W'(1) : '0;
      end else if (cmd.shift_zero) begin
         flush_in = flush_ff - TAP_CNT_W'(1);
      end
   end

   // shared multiply-accumulate, product registered ahead of the add
   always_comb begin
      mac_idx_in  = mac_idx_ff;
      prod_vld_in = 1'b0;
      acc_in      = acc_ff;
      if (prod_vld_ff) begin
         if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_in = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
         end else begin
            acc_in = acc_sum[ACC_W-1:0];
         end
      end
      if (cmd.mac_start) begin
         mac_idx_in = '0;
         acc_in     = '0;
      end else if (cmd.mac_run && mac_active) begin
         mac_idx_in  = mac_idx_ff + TAP_CNT_W'(1);
         prod_vld_in = 1'b1;
      end
   end

   always_comb begin
      emit_cnt_in  = emit_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      len_in       = csr_valid ? csr_data : len_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = acc_ff;
         rsp_last_in  = (last_ff && flush_ff == '0) || len_hit;
         if (emit_cnt_ff != '1) begin
            emit_cnt_in = emit_cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.finish) begin
         emit_cnt_in = '0;
      end
   end

   assign stat.mac_busy   = mac_active || prod_vld_ff;
   assign stat.suppress   = (len_ff != '0) && (emit_cnt_ff >= {1'b0, len_ff});
   assign stat.flush_more = (flush_ff != '0);
   assign stat.seq_last   = last_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      kern_ff     <= kern_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      flush_ff    <= flush_in;
      last_ff     <= last_in;
      mac_idx_ff  <= mac_idx_in;
      acc_ff      <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            hist_ff[i] <= '0;
         end
         tap_cnt_ff   <= '0;
         closed_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         emit_cnt_ff  <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hist_ff      <= hist_in;
         tap_cnt_ff   <= tap_cnt_in;
         closed_ff    <= closed_in;
         prod_vld_ff  <= prod_vld_in;
         emit_cnt_ff  <= emit_cnt_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/full_linear_convolution_top.sv
// full linear convolution of a sample stream with a loaded kernel of up to
// MAX_TAPS Q1.15 coefficients. a transaction with tuser 0 loads the next
// coefficient (tlast closes the kernel, the next coefficient then starts a
// new one); tuser 1 supplies a signed 16-bit sample. each sample gives one
// 40-bit saturated Q25.15 result, and a sample with tlast also flushes the
// tap_count-1 tail results and clears the history. csr_data sets the output
// length (0 means full length); results past it are dropped. the input stays
// ready after a coefficient. a sample is held off while its results are
// computed by the single shared multiply-accumulate unit, which walks the
// taps one per cycle; results may wait on rsp_tready. the user must write
// configuration only while the block is idle; the block does not enforce it.
module full_linear_convolution_top (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [flc_pkg::SAMPLE_W-1:0]        req_tdata,   // [15:0] value
   input  logic                                req_tuser,   // [0] operation
   input  logic                                req_tlast,   // is_last
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [flc_pkg::ACC_W-1:0]           rsp_tdata,   // [39:0] result
   output logic                                rsp_tlast,   // result_last
   // configuration write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [flc_pkg::LEN_W-1:0]           csr_data     // out_length
);
   import flc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // length register accepts a write in any cycle
   assign csr_ready = 1'b1;

   // sequencer: accepts transactions and steps the datapath per result
   flc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

   // kernel, history, mac unit, counters and output register
   flc_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .in_value   (signed'(req_tdata)),
      .in_last    (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hw/rtl/flc_checker.sv
`include "full_linear_convolution_top_defines.svh"

module flc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       req_tuser,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [flc_pkg::ACC_W-1:0]  rsp_tdata,
   input logic                       rsp_tlast
);
   import flc_pkg::*;

   logic           req_acc;
   logic           rsp_stall;
   logic [ACC_W:0] rsp_word;

   assign req_acc   = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tlast, rsp_tdata};

   // a coefficient never stalls the input
   `FLC_ASSERT_NEXT(a_coef_no_stall, clock, reset, req_acc && req_tuser == OP_COEF, req_tready)
   // a sample holds off the input while its results are computed
   `FLC_ASSERT_NEXT(a_sample_busy, clock, reset, req_acc && req_tuser == OP_SAMPLE, !req_tready)
   // stalled result holds
   `FLC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))
   // a valid result carries a known last flag
   `FLC_ASSERT_SAME(a_rsp_known, clock, reset, rsp_tvalid, !$isunknown(rsp_tlast))

endmodule

bind full_linear_convolution_top flc_checker u_flc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### sim/tb_full_linear_convolution_top.sv
`timescale 1ns / 1ps

import flc_pkg::*;

typedef struct {
   logic [ACC_W-1:0] value;
   logic             tail;
} conv_result_type;

// tracks kernel and sample history, predicts each convolution output
class conv_checker;
   logic signed [SAMPLE_W-1:0] kern [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] hist [MAX_TAPS];
   int unsigned taps;
   bit          closed;
   int unsigned emitted;
   int unsigned out_len;
   conv_result_type pending_results[$];
   int mismatches;
   int received;

   function new();
      foreach (kern[i]) kern[i] = '0;
      foreach (hist[i]) hist[i] = '0;
      taps = 0;
      closed = 0;
      emitted = 0;
      out_len = 0;
      mismatches = 0;
      received = 0;
   endfunction

   function void set_out_length(int unsigned len);
      out_len = len & 16'hFFFF;
   endfunction

   function int pending();
      return pending_results.size();
   endfunction

   function void shift_sample(logic signed [SAMPLE_W-1:0] s);
      for (int i = MAX_TAPS - 1; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = s;
   endfunction

   // saturating multiply-accumulate over the loaded taps
   function longint tap_sum();
      longint acc;
      acc = 0;
      for (int j = 0; j < taps && j < MAX_TAPS; j++) begin
         acc += longint'(kern[j]) * longint'(hist[j]);
         if (acc > 64'sd549755813887) acc = 64'sd549755813887;
         if (acc < -64'sd549755813888) acc = -64'sd549755813888;
      end
      return acc;
   endfunction

   function void predict_output(bit seq_end);
      conv_result_type r;
      longint acc;
      if (out_len != 0 && emitted >= out_len) return;
      acc = tap_sum();
      r.value = acc[ACC_W-1:0];
      r.tail = seq_end || (out_len != 0 && emitted + 1 == out_len);
      pending_results.insert(pending_results.size(), r);
      if (emitted < 131071) emitted++;
   endfunction

   // one accepted input transaction
   function void take_input(logic op, logic signed [SAMPLE_W-1:0] val, logic last);
      int unsigned flush;
      if (op == OP_COEF) begin
         if (closed) begin
            taps = 0;
            closed = 0;
         end
         if (taps < MAX_TAPS) begin
            kern[taps] = val;
            taps++;
         end
         if (last) closed = 1;
         return;
      end
      flush = (last && taps > 1) ? taps - 1 : 0;
      shift_sample(val);
      predict_output(last && flush == 0);
      for (int f = 1; f <= flush; f++) begin
         shift_sample('0);
         predict_output(f == flush);
      end
      if (last) begin
         foreach (hist[i]) hist[i] = '0;
         emitted = 0;
      end
   endfunction

   function void check_result(logic [ACC_W-1:0] got, logic got_last);
      conv_result_type want;
      received++;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual data %h last %b",
                  $time, got, got_last);
         mismatches++;
         return;
      end
      want = pending_results.pop_front();
      if (got !== want.value) begin
         $display("%0t: result data mismatch, expected %h actual %h",
                  $time, want.value, got);
         mismatches++;
      end
      if (got_last !== want.tail) begin
         $display("%0t: result last mismatch, expected %b actual %b",
                  $time, want.tail, got_last);
         mismatches++;
      end
   endfunction
endclass

module tb_full_linear_convolution_top;

   localparam int SETTLE_CYCLES = 400;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata;
   logic                req_tuser;
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [ACC_W-1:0]    rsp_tdata;
   logic                rsp_tlast;
   logic                csr_valid;
   logic                csr_ready;
   logic [LEN_W-1:0]    csr_data;

   conv_checker sb = new();

   // idling knobs, percent of cycles
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   // long receiver hold-off, armed by the stimulus and counted by the receiver
   bit hold_off_request = 0;
   int items_sent = 0;

   always #2 clock = ~clock;

   full_linear_convolution_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // offer one transaction, with random idle cycles ahead of it
   task automatic send_item(logic op, logic [SAMPLE_W-1:0] val, logic last);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.take_input(op, val, last);
      items_sent++;
   endtask

   // mostly random, sometimes an extreme
   function automatic logic [SAMPLE_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_kernel(int n, bit close);
      for (int i = 0; i < n; i++) send_item(OP_COEF, pick_value(), close && i == n - 1);
   endtask

   task automatic send_signal(int n, bit close);
      for (int i = 0; i < n; i++) send_item(OP_SAMPLE, pick_value(), close && i == n - 1);
   endtask

   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_out_length(int unsigned len);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= LEN_W'(len);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_out_length(len);
   endtask

   // random traffic, mostly complete kernel + signal sequences
   task automatic run_random(int count);
      int first_items;
      int taps;
      first_items = items_sent;
      while (items_sent - first_items < count) begin
         taps = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 18);
         case ($urandom_range(0, 9))
            7: begin
               // signal against a kernel still open
               send_kernel($urandom_range(1, 4), 0);
               send_signal($urandom_range(1, 6), 1);
            end
            8: begin
               // coefficient slipped into a running signal
               send_signal($urandom_range(1, 4), 0);
               send_item(OP_COEF, pick_value(), 1'($urandom_range(0, 1)));
               send_signal($urandom_range(1, 4), 1);
            end
            9: begin
               // stray samples, signal left running
               send_signal($urandom_range(1, 3), 0);
            end
            default: begin
               send_kernel(taps, 1);
               send_signal($urandom_range(1, 10), 1);
            end
         endcase
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic run_phase(int unsigned len, int send_pct, int recv_pct, bit hold,
                            int count);
      write_out_length(len);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      if (hold) hold_off_request = 1;
      run_random(count);
   endtask

   // directed corner cases at full output length, no idling
   task automatic run_directed();
      // no taps yet: outputs of zero, no flushed tail
      send_item(OP_SAMPLE, 16'h7FFF, 1'b0);
      send_item(OP_SAMPLE, 16'h8000, 1'b1);
      // seventeen coefficients: the last is dropped but still closes the kernel
      for (int i = 0; i < MAX_TAPS + 1; i++)
         send_item(OP_COEF, (i % 2) ? 16'h7FFF : 16'h8000, i == MAX_TAPS);
      // a full tail of MAX_TAPS - 1 flushed outputs
      send_item(OP_SAMPLE, 16'h8000, 1'b0);
      send_item(OP_SAMPLE, 16'h7FFF, 1'b1);
      // new kernel begun mid-signal, used before it is closed
      send_item(OP_SAMPLE, 16'h5555, 1'b0);
      send_item(OP_COEF, 16'h7FFF, 1'b0);
      send_item(OP_COEF, 16'hFFFF, 1'b0);
      send_item(OP_SAMPLE, 16'hAAAA, 1'b1);
      send_item(OP_COEF, 16'h3039, 1'b1);
      req_tvalid <= 1'b0;
   endtask

   // receiver: checks each result transaction and stalls at random
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
         if (hold_off_request) begin
            hold_off_request = 0;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // stimulus and end of run
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_COEF;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_out_length(0);
      run_directed();

      run_phase(65535, 0, 45, 0, 46);
      run_phase(1, 10, 10, 0, 46);
      // receiver held off so the block backs up into its input
      run_phase(3, 0, 0, 1, 46);
      run_phase($urandom_range(2, 40), 45, 0, 0, 46);
      run_phase(0, 0, 0, 0, 46);

      wait_idle();
      if (sb.mismatches == 0) begin
         $display("full_linear_convolution_top verification clean");
      end else begin
         $display("full_linear_convolution_top verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8_000_000;
      $display("full_linear_convolution_top verification failed");
      $finish;
   end

endmodule

### full_linear_convolution_top.f
+incdir+hw/rtl
hw/rtl/flc_pkg.sv
hw/rtl/flc_ctrl.sv
hw/rtl/flc_datapath.sv
hw/rtl/full_linear_convolution_top.sv
hw/rtl/flc_checker.sv
sim/tb_full_linear_convolution_top.sv
